### rtl/vsa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vsa_pkg
// Shared constants, types and helper functions of the voice slot allocator.
// ----------------------------------------------------------------------------
package vsa_pkg;

  localparam int unsigned VOICES      = 16;
  localparam int unsigned SOUND_KINDS = 12;
  localparam int unsigned SLOT_W      = (VOICES > 1) ? $clog2(VOICES) : 1;

  localparam logic [14:0] GAIN_MAX     = 15'd16384;
  localparam logic [15:0] PITCH_ONE    = 16'd256;
  localparam logic [31:0] RNG_RESET    = 32'h00C0_FFEE;
  localparam logic [31:0] RNG_ZERO_FIX = 32'h9E37_79B9;

  localparam logic OP_START  = 1'b0;
  localparam logic OP_FINISH = 1'b1;

  // search token handed from cell to cell
  typedef struct packed {
    logic              valid;
    logic              found;
    logic              has_best;
    logic [SLOT_W-1:0] idx;
    logic [31:0]       age;
  } tok_t;

  // write broadcast to the cell row
  typedef struct packed {
    logic              start_en;
    logic              free_en;
    logic [SLOT_W-1:0] idx;
    logic [3:0]        kind;
    logic [14:0]       gain;
    logic [15:0]       pitch;
    logic [31:0]       seed;
    logic [31:0]       age;
  } wr_t;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_RES  = 3'b100
  } state_t;

  function automatic logic [31:0] xorshift32(input logic [31:0] s);
    logic [31:0] x;
    x = (s == 32'd0) ? RNG_ZERO_FIX : s;
    x = x ^ (x << 13);
    x = x ^ (x >> 17);
    x = x ^ (x << 5);
    return x;
  endfunction

  function automatic logic [14:0] clamp_gain(input logic signed [15:0] g);
    logic [14:0] r;
    if (g[15]) begin
      r = 15'd0;
    end else if (g > $signed({1'b0, GAIN_MAX})) begin
      r = GAIN_MAX;
    end else begin
      r = g[14:0];
    end
    return r;
  endfunction

endpackage

### rtl/vsa_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vsa_in_if / vsa_out_if
// Valid/ready channels for request items and result items.
// ----------------------------------------------------------------------------
interface vsa_in_if;
  logic               valid;
  logic               ready;
  logic               op;
  logic [3:0]         sound_kind;
  logic signed [15:0] gain_level;
  logic [15:0]        pitch_rate;
  logic [3:0]         finish_slot;

  modport source (output valid, op, sound_kind, gain_level, pitch_rate, finish_slot,
                  input ready);
  modport sink (input valid, op, sound_kind, gain_level, pitch_rate, finish_slot,
                output ready);
endinterface

interface vsa_out_if;
  logic        valid;
  logic        ready;
  logic        accepted;
  logic [3:0]  chosen_slot;
  logic        was_stolen;
  logic [31:0] voice_seed;
  logic [31:0] voice_age;

  modport source (output valid, accepted, chosen_slot, was_stolen, voice_seed, voice_age,
                  input ready);
  modport sink (input valid, accepted, chosen_slot, was_stolen, voice_seed, voice_age,
                output ready);
endinterface

### rtl/vsa_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vsa_cell
// One voice slot: holds the slot state and updates the passing search token.
// ----------------------------------------------------------------------------
module vsa_cell (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [vsa_pkg::SLOT_W-1:0] cell_idx,
  input  vsa_pkg::wr_t               wr,
  input  vsa_pkg::tok_t              tok_in,
  output vsa_pkg::tok_t              tok_out,
  output logic                       busy
);

  logic        busy_r;
  logic [3:0]  kind_r;
  logic [14:0] gain_r;
  logic [15:0] pitch_r;
  logic [31:0] seed_r;
  logic [31:0] age_r;
  vsa_pkg::tok_t tok_r, tok_nxt;
  logic        hit;

  assign hit = (wr.idx == cell_idx);

  // lowest free slot wins, else strictly smaller age
  always_comb begin
    tok_nxt = tok_in;
    if (tok_in.valid && !tok_in.found) begin
      if (!busy_r) begin
        tok_nxt.found = 1'b1;
        tok_nxt.idx   = cell_idx;
      end else if (!tok_in.has_best || (age_r < tok_in.age)) begin
        tok_nxt.has_best = 1'b1;
        tok_nxt.idx      = cell_idx;
        tok_nxt.age      = age_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r  <= '0;
      busy_r <= 1'b0;
    end else begin
      tok_r <= tok_nxt;
      if (wr.start_en && hit) begin
        busy_r <= 1'b1;
      end else if (wr.free_en && hit) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr.start_en && hit) begin
      kind_r  <= wr.kind;
      gain_r  <= wr.gain;
      pitch_r <= wr.pitch;
      seed_r  <= wr.seed;
      age_r   <= wr.age;
    end
  end

  assign tok_out = tok_r;
  assign busy    = busy_r;

endmodule

### rtl/voice_slot_allocator_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// voice_slot_allocator_core
// Voice slot allocator: start requests take the lowest free slot or steal the
// oldest one; finish requests free a slot.
// ----------------------------------------------------------------------------
// order: a start passes the token walk along the cell row and the latch of the
//   search outcome, then the write-back; a finish or reject goes straight to it
// flow: one item at a time, no new request is taken until the result is loaded,
//   plus any stall on the result channel
// reset: synchronous, active low; clears all busy bits, the age counter, the
//   token pipeline and the output valid flag, loads the generator with 0xC0FFEE
module voice_slot_allocator_core (
  input  logic            clk,
  input  logic            rst_n,
  vsa_in_if.sink          in_ch,
  vsa_out_if.source       out_ch
);

  localparam int unsigned NV = vsa_pkg::VOICES;
  localparam int unsigned SW = vsa_pkg::SLOT_W;

  vsa_pkg::state_t state_r, state_nxt;

  // latched request
  logic               req_op_r;
  logic [3:0]         req_kind_r;
  logic signed [15:0] req_gain_r;
  logic [15:0]        req_pitch_r;
  logic [3:0]         req_fslot_r;

  // search outcome
  logic          found_r;
  logic [SW-1:0] slot_r;

  logic [31:0] age_ctr_r;
  logic [31:0] rng_r;

  // output register
  logic        out_valid_r;
  logic        out_acc_r;
  logic [3:0]  out_slot_r;
  logic        out_stolen_r;
  logic [31:0] out_seed_r;
  logic [31:0] out_age_r;

  // cell row
  vsa_pkg::tok_t tok_chain [NV+1];
  logic [NV-1:0] busy_vec;
  vsa_pkg::wr_t  wr;

  logic          accept_in;
  logic          kind_ok;
  logic          req_start_ok;
  logic [SW-1:0] fidx;
  logic          free_ok;
  logic          out_free;
  logic          res_load;
  logic [31:0]   rng_next;

  assign accept_in = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state_r == vsa_pkg::S_IDLE);

  // incoming kind range check decides whether a search is launched
  assign kind_ok = (32'(in_ch.sound_kind) < 32'(vsa_pkg::SOUND_KINDS));

  // token injected into the first cell on an accepted, in-range start
  always_comb begin
    tok_chain[0]          = '0;
    tok_chain[0].valid    = accept_in && (in_ch.op == vsa_pkg::OP_START) && kind_ok;
  end

  for (genvar i = 0; i < NV; i++) begin : g_cell
    vsa_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cell_idx (SW'(i)),
      .wr       (wr),
      .tok_in   (tok_chain[i]),
      .tok_out  (tok_chain[i+1]),
      .busy     (busy_vec[i])
    );
  end

  // latched request checks, evaluated in the result cycle
  assign req_start_ok = (req_op_r == vsa_pkg::OP_START) &&
                        (32'(req_kind_r) < 32'(vsa_pkg::SOUND_KINDS));
  assign fidx    = SW'(req_fslot_r);
  assign free_ok = (req_op_r == vsa_pkg::OP_FINISH) &&
                   (32'(req_fslot_r) < 32'(NV)) && busy_vec[fidx];

  assign out_free = !out_valid_r || out_ch.ready;
  assign res_load = (state_r == vsa_pkg::S_RES) && out_free;
  assign rng_next = vsa_pkg::xorshift32(rng_r);

  // write broadcast: new voice into the chosen slot, or busy clear on finish
  always_comb begin
    wr          = '0;
    wr.start_en = res_load && req_start_ok;
    wr.free_en  = res_load && free_ok;
    wr.idx      = req_start_ok ? slot_r : fidx;
    wr.kind     = req_kind_r;
    wr.gain     = vsa_pkg::clamp_gain(req_gain_r);
    wr.pitch    = (req_pitch_r == 16'd0) ? vsa_pkg::PITCH_ONE : req_pitch_r;
    wr.seed     = rng_next | 32'd1;
    wr.age      = age_ctr_r;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      vsa_pkg::S_IDLE: begin
        if (accept_in) begin
          state_nxt = tok_chain[0].valid ? vsa_pkg::S_SCAN : vsa_pkg::S_RES;
        end
      end
      vsa_pkg::S_SCAN: begin
        if (tok_chain[NV].valid) begin
          state_nxt = vsa_pkg::S_RES;
        end
      end
      vsa_pkg::S_RES: begin
        if (out_free) begin
          state_nxt = vsa_pkg::S_IDLE;
        end
      end
      default: state_nxt = vsa_pkg::S_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= vsa_pkg::S_IDLE;
      age_ctr_r   <= 32'd0;
      rng_r       <= vsa_pkg::RNG_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (wr.start_en) begin
        age_ctr_r <= age_ctr_r + 32'd1;
        rng_r     <= rng_next;
      end
      if (res_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept_in) begin
      req_op_r    <= in_ch.op;
      req_kind_r  <= in_ch.sound_kind;
      req_gain_r  <= in_ch.gain_level;
      req_pitch_r <= in_ch.pitch_rate;
      req_fslot_r <= in_ch.finish_slot;
    end
    if ((state_r == vsa_pkg::S_SCAN) && tok_chain[NV].valid) begin
      found_r <= tok_chain[NV].found;
      slot_r  <= tok_chain[NV].idx;
    end
    if (res_load) begin
      if (req_start_ok) begin
        out_acc_r    <= 1'b1;
        out_slot_r   <= 4'(slot_r);
        out_stolen_r <= !found_r;
        out_seed_r   <= wr.seed;
        out_age_r    <= age_ctr_r;
      end else if (free_ok) begin
        out_acc_r    <= 1'b1;
        out_slot_r   <= req_fslot_r;
        out_stolen_r <= 1'b0;
        out_seed_r   <= 32'd0;
        out_age_r    <= 32'd0;
      end else begin
        // rejected item
        out_acc_r    <= 1'b0;
        out_slot_r   <= 4'd0;
        out_stolen_r <= 1'b0;
        out_seed_r   <= 32'd0;
        out_age_r    <= 32'd0;
      end
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.accepted    = out_acc_r;
  assign out_ch.chosen_slot = out_slot_r;
  assign out_ch.was_stolen  = out_stolen_r;
  assign out_ch.voice_seed  = out_seed_r;
  assign out_ch.voice_age   = out_age_r;

`ifndef SYNTHESIS
  // the search token only leaves the row while the scan is running
  a_tok_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    tok_chain[NV].valid |-> (state_r == vsa_pkg::S_SCAN))
    else $error("search token left the cell row outside a scan");

  // a steal only happens when every slot is busy, and all stay busy
  a_steal_full: assert property (@(posedge clk) disable iff (!rst_n)
    (wr.start_en && !found_r) |=> (&busy_vec))
    else $error("voice stolen while a slot was free");

  // a new voice always gets an odd seed
  a_seed_odd: assert property (@(posedge clk) disable iff (!rst_n)
    wr.start_en |=> (out_seed_r[0] && out_acc_r && out_valid_r))
    else $error("started voice result without odd seed");

  // a result only appears after the result cycle
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == vsa_pkg::S_RES))
    else $error("result raised outside the result cycle");
`endif

endmodule
